[rtl/droe_pkg.sv]
// ---------------------------------------------------------------------------
// droe_pkg: shared types and constants of the depth raster occlusion engine
// Payload structs, operation and register codes, and the fixed widths of
// the edge-function and depth-interpolation datapaths.
// ---------------------------------------------------------------------------
package droe_pkg;

  localparam int MAX_WIDTH       = 256;
  localparam int MAX_HEIGHT      = 256;
  localparam int COORD_FRAC_BITS = 4;
  localparam int STORE_DEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W          = $clog2(STORE_DEPTH);
  localparam int DIM_W           = 9;
  localparam int COORD_W         = 20;
  localparam int DEPTH_W         = 32;
  localparam int COUNT_W         = 17;
  localparam int CFG_IDX_W       = 2;

  // edge functions, weights and the long-division remainder
  localparam int K_W    = 48;
  localparam int HALF_W = K_W / 2;
  localparam int MP_W   = HALF_W + DEPTH_W;
  localparam int ACC_W  = K_W + DEPTH_W;
  localparam int REM_W  = K_W + 1;
  localparam int DIFF_W = COORD_W + 2;
  localparam int PROD_W = 2 * DIFF_W;

  localparam logic [DEPTH_W-1:0] DEPTH_CEILING = 32'hFFFF_FF00;
  localparam logic [DEPTH_W-1:0] DEPTH_CLEAR   = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_TRI   = 2'd2;
  localparam logic [1:0] OP_TEST  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic [1:0]                op;
    logic [15:0]               pixel_index;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic [DEPTH_W-1:0]        az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic [DEPTH_W-1:0]        bz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [DEPTH_W-1:0]        cz;
  } droe_in_t;

  typedef struct packed {
    logic               visible;
    logic [COUNT_W-1:0] pixels_covered;
  } droe_out_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [DEPTH_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } droe_mem_req_t;

  typedef struct packed {
    logic               start;
    logic [K_W-1:0]     w0;
    logic [K_W-1:0]     w1;
    logic [K_W-1:0]     w2;
    logic [K_W-1:0]     sum;
    logic [DEPTH_W-1:0] z0;
    logic [DEPTH_W-1:0] z1;
    logic [DEPTH_W-1:0] z2;
  } droe_ip_req_t;

  typedef struct packed {
    logic               done;
    logic [DEPTH_W-1:0] depth;
  } droe_ip_rsp_t;

  function automatic logic [DEPTH_W-1:0] sat_depth(input logic [DEPTH_W-1:0] v);
    return (v > DEPTH_CEILING) ? DEPTH_CEILING : v;
  endfunction

endpackage

[rtl/droe_store.sv]
// ---------------------------------------------------------------------------
// droe_store: depth store
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module droe_store import droe_pkg::*; (
  input  logic               clk,
  input  droe_mem_req_t      req,
  output logic [DEPTH_W-1:0] rd_data
);

  logic [DEPTH_W-1:0] mem [STORE_DEPTH];
  logic [DEPTH_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/droe_interp.sv]
// ---------------------------------------------------------------------------
// droe_interp: depth interpolation unit
// Sums w0*z0 + w1*z1 + w2*z2 with one 24x32 multiplier, then divides by the
// weight sum one quotient bit per cycle.
// ---------------------------------------------------------------------------
module droe_interp import droe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  droe_ip_req_t req,
  output droe_ip_rsp_t rsp
);

  typedef enum logic [2:0] {
    IP_IDLE = 3'b001,
    IP_MUL  = 3'b010,
    IP_DIV  = 3'b100
  } ip_state_t;

  ip_state_t            state_r;
  logic [K_W-1:0]       w0_r, w1_r, w2_r, sum_r;
  logic [DEPTH_W-1:0]   z0_r, z1_r, z2_r;
  logic [2:0]           mcnt_r;
  logic [4:0]           dcnt_r;
  logic [MP_W-1:0]      prod_r;
  logic                 prod_hi_r;
  logic [ACC_W-1:0]     acc_r;
  logic [REM_W-1:0]     rem_r;
  logic [DEPTH_W-1:0]   num_r, q_r, depth_r;
  logic                 done_r;

  logic [HALF_W-1:0]    mul_w;
  logic [DEPTH_W-1:0]   mul_z;
  logic [MP_W-1:0]      prod;
  logic [ACC_W-1:0]     acc_add, acc_sum;
  logic [REM_W-1:0]     rem_sh, rem_sub;
  logic                 ge;

  always_comb begin
    case (mcnt_r)
      3'd0:    begin mul_w = w0_r[HALF_W-1:0];   mul_z = z0_r; end
      3'd1:    begin mul_w = w0_r[K_W-1:HALF_W]; mul_z = z0_r; end
      3'd2:    begin mul_w = w1_r[HALF_W-1:0];   mul_z = z1_r; end
      3'd3:    begin mul_w = w1_r[K_W-1:HALF_W]; mul_z = z1_r; end
      3'd4:    begin mul_w = w2_r[HALF_W-1:0];   mul_z = z2_r; end
      3'd5:    begin mul_w = w2_r[K_W-1:HALF_W]; mul_z = z2_r; end
      default: begin mul_w = '0;                 mul_z = '0;   end
    endcase
  end

  assign prod    = MP_W'(mul_w) * MP_W'(mul_z);
  assign acc_add = prod_hi_r ? {prod_r, {HALF_W{1'b0}}} : {{HALF_W{1'b0}}, prod_r};
  assign acc_sum = acc_r + acc_add;

  // restoring division; the quotient fits 32 bits since weights sum to sum_r
  assign rem_sh  = {rem_r[REM_W-2:0], num_r[DEPTH_W-1]};
  assign ge      = rem_sh >= {1'b0, sum_r};
  assign rem_sub = rem_sh - {1'b0, sum_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IP_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        IP_IDLE: begin
          if (req.start) begin
            w0_r    <= req.w0;
            w1_r    <= req.w1;
            w2_r    <= req.w2;
            sum_r   <= req.sum;
            z0_r    <= req.z0;
            z1_r    <= req.z1;
            z2_r    <= req.z2;
            acc_r   <= '0;
            mcnt_r  <= '0;
            state_r <= IP_MUL;
          end
        end
        IP_MUL: begin
          prod_r    <= prod;
          prod_hi_r <= mcnt_r[0];
          if (mcnt_r != 3'd0) begin
            acc_r <= acc_sum;
          end
          mcnt_r <= mcnt_r + 3'd1;
          if (mcnt_r == 3'd6) begin
            rem_r   <= {1'b0, acc_sum[ACC_W-1:DEPTH_W]};
            num_r   <= acc_sum[DEPTH_W-1:0];
            dcnt_r  <= '0;
            state_r <= IP_DIV;
          end
        end
        IP_DIV: begin
          rem_r  <= ge ? rem_sub : rem_sh;
          num_r  <= {num_r[DEPTH_W-2:0], 1'b0};
          q_r    <= {q_r[DEPTH_W-2:0], ge};
          dcnt_r <= dcnt_r + 5'd1;
          if (dcnt_r == 5'd31) begin
            depth_r <= sat_depth({q_r[DEPTH_W-2:0], ge});
            done_r  <= 1'b1;
            state_r <= IP_IDLE;
          end
        end
        default: state_r <= IP_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.depth = depth_r;

endmodule

[rtl/depth_raster_occlusion_engine.sv]
// ---------------------------------------------------------------------------
// depth_raster_occlusion_engine: occlusion depth rasterizer
//
//   channel  ports                         role
//   in       in_valid in_stall in_data     operation in (clear/fill/tri/test)
//   out      out_valid out_stall out_data  one result per operation
//   cfg      cfg_valid cfg_ready cfg_index cfg_data  frame width / height
//
// Clear sweeps the whole store; the same sweep runs after reset with in_stall
// high. A triangle sets up its box and edge functions, a test its box, then
// the box is walked one pixel per cycle while no covered pixel holds it; each
// covered pixel of a triangle holds the walk for the interpolation unit (six
// multiplies and a 32-step divide) plus a read and write of the store. A test
// stops at the first visible pixel. The result waits in an output register
// under out_stall.
// ---------------------------------------------------------------------------
module depth_raster_occlusion_engine import droe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  droe_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output droe_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_CLEAR   = 14'b00000000000010,
    ST_FILL    = 14'b00000000000100,
    ST_BOX     = 14'b00000000001000,
    ST_BASE    = 14'b00000000010000,
    ST_TMUL    = 14'b00000000100000,
    ST_NORM    = 14'b00000001000000,
    ST_TPIX    = 14'b00000010000000,
    ST_TINTERP = 14'b00000100000000,
    ST_TREAD   = 14'b00001000000000,
    ST_TWRITE  = 14'b00010000000000,
    ST_TWALK   = 14'b00100000000000,
    ST_TDRAIN  = 14'b01000000000000,
    ST_DONE    = 14'b10000000000000
  } state_t;

  state_t                    state_r, state_nxt;
  droe_in_t                  item_r;
  logic [DIM_W-1:0]          width_r, height_r;
  logic [DIM_W-1:0]          box_x0_r, box_x1_r, box_y0_r, box_y1_r;
  logic [DIM_W-1:0]          x_r, y_r;
  logic [ADDR_W:0]           row_base_r;
  logic signed [DIFF_W-1:0]  dcax_r, dcay_r, dbax_r, dbay_r, dapx_r, dapy_r;
  logic [2:0]                mcnt_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [K_W-1:0]     kz_r, kx_r, ky_r, kx_row_r, ky_row_r;
  logic signed [K_W-1:0]     ix_kx_r, ix_ky_r, iy_kx_r, iy_ky_r;
  logic [COUNT_W-1:0]        cnt_r;
  logic                      vis_r;
  logic [ADDR_W-1:0]         clr_cnt_r;
  logic                      clr_init_r;
  logic                      rd_vld_r;
  logic                      out_valid_r;
  droe_out_t                 out_data_r;

  logic [DIM_W-1:0]          w_act, h_act;
  logic signed [COORD_W-1:0] minx, maxx, miny, maxy;
  logic signed [COORD_W:0]   t_lo_x, t_hi_x, t_lo_y, t_hi_y;
  logic signed [COORD_W:0]   fl_x, ce_x, fl_y, ce_y;
  logic [DIM_W-1:0]          bx0, bx1, by0, by1;
  logic signed [DIFF_W-1:0]  mul_a, mul_b;
  logic signed [K_W-1:0]     prod_ext, w0_s;
  logic signed [K_W-1:0]     kz_neg, kx_neg, ky_neg;
  logic [DIM_W:0]            x_inc, y_inc;
  logic                      last_x, last_y, walk_end;
  logic [ADDR_W-1:0]         pix_addr;
  logic [2*DIM_W-1:0]        area, base_prod;
  logic                      covered, hit_now, box_empty, out_free;
  logic [DEPTH_W-1:0]        rd_data;
  droe_mem_req_t             mem_req;
  droe_ip_req_t              ip_req;
  droe_ip_rsp_t              ip_rsp;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic signed [COORD_W:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic signed [COORD_W:0] lim_s;
    lim_s = $signed({{(COORD_W+1-DIM_W){1'b0}}, lim});
    if (v < 0) begin
      return '0;
    end else if (v > lim_s) begin
      return lim;
    end else begin
      return v[DIM_W-1:0];
    end
  endfunction

  function automatic logic signed [K_W-1:0] sx(input logic signed [DIFF_W-1:0] v);
    return {{(K_W-DIFF_W){v[DIFF_W-1]}}, v};
  endfunction

  // active frame size: zero acts as one, above the maximum acts as maximum
  assign w_act = (width_r == '0) ? DIM_W'(1) :
                 ((width_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_r);
  assign h_act = (height_r == '0) ? DIM_W'(1) :
                 ((height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_r);

  // bounding box: floor of the minimum, ceil of the maximum (a test uses its corners)
  always_comb begin
    minx = (item_r.ax < item_r.bx) ? item_r.ax : item_r.bx;
    minx = (minx < item_r.cx) ? minx : item_r.cx;
    maxx = (item_r.ax > item_r.bx) ? item_r.ax : item_r.bx;
    maxx = (maxx > item_r.cx) ? maxx : item_r.cx;
    miny = (item_r.ay < item_r.by) ? item_r.ay : item_r.by;
    miny = (miny < item_r.cy) ? miny : item_r.cy;
    maxy = (item_r.ay > item_r.by) ? item_r.ay : item_r.by;
    maxy = (maxy > item_r.cy) ? maxy : item_r.cy;
    t_lo_x = {minx[COORD_W-1], minx};
    t_lo_y = {miny[COORD_W-1], miny};
    t_hi_x = {maxx[COORD_W-1], maxx} + (COORD_W+1)'((1 << COORD_FRAC_BITS) - 1);
    t_hi_y = {maxy[COORD_W-1], maxy} + (COORD_W+1)'((1 << COORD_FRAC_BITS) - 1);
    fl_x = t_lo_x >>> COORD_FRAC_BITS;
    fl_y = t_lo_y >>> COORD_FRAC_BITS;
    ce_x = t_hi_x >>> COORD_FRAC_BITS;
    ce_y = t_hi_y >>> COORD_FRAC_BITS;
    if (item_r.op == OP_TEST) begin
      bx0 = clamp_dim({item_r.ax[COORD_W-1], item_r.ax}, w_act);
      by0 = clamp_dim({item_r.ay[COORD_W-1], item_r.ay}, h_act);
      bx1 = clamp_dim({item_r.bx[COORD_W-1], item_r.bx}, w_act);
      by1 = clamp_dim({item_r.by[COORD_W-1], item_r.by}, h_act);
    end else begin
      bx0 = clamp_dim(fl_x, w_act);
      by0 = clamp_dim(fl_y, h_act);
      bx1 = clamp_dim(ce_x, w_act);
      by1 = clamp_dim(ce_y, h_act);
    end
  end

  assign box_empty = (box_x0_r >= box_x1_r) || (box_y0_r >= box_y1_r);
  assign base_prod = (2*DIM_W)'(box_y0_r) * (2*DIM_W)'(w_act);
  assign area      = (2*DIM_W)'(w_act) * (2*DIM_W)'(h_act);

  // shared setup multiplier: kz, then kx and ky at the box origin
  always_comb begin
    case (mcnt_r)
      3'd0:    begin mul_a = dcax_r; mul_b = dbay_r; end
      3'd1:    begin mul_a = dbax_r; mul_b = dcay_r; end
      3'd2:    begin mul_a = dbax_r; mul_b = dapy_r; end
      3'd3:    begin mul_a = dapx_r; mul_b = dbay_r; end
      3'd4:    begin mul_a = dapx_r; mul_b = dcay_r; end
      3'd5:    begin mul_a = dcax_r; mul_b = dapy_r; end
      default: begin mul_a = '0;     mul_b = '0;     end
    endcase
  end

  assign prod_ext = {{(K_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign kz_neg   = -kz_r;
  assign kx_neg   = -kx_r;
  assign ky_neg   = -ky_r;

  assign w0_s    = kz_r - kx_r - ky_r;
  assign covered = !w0_s[K_W-1] && !kx_r[K_W-1] && !ky_r[K_W-1];

  assign x_inc    = {1'b0, x_r} + (DIM_W+1)'(1);
  assign y_inc    = {1'b0, y_r} + (DIM_W+1)'(1);
  assign last_x   = x_inc == {1'b0, box_x1_r};
  assign last_y   = y_inc == {1'b0, box_y1_r};
  assign walk_end = last_x && last_y;
  assign pix_addr = row_base_r[ADDR_W-1:0] + ADDR_W'(x_r);

  assign hit_now  = rd_vld_r && (rd_data > item_r.az);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.op)
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_FILL:  state_nxt = ST_FILL;
            default:  state_nxt = ST_BOX;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = clr_init_r ? ST_IDLE : ST_DONE;
        end
      end
      ST_FILL:  state_nxt = ST_DONE;
      ST_BOX:   state_nxt = ST_BASE;
      ST_BASE: begin
        if (box_empty) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = (item_r.op == OP_TEST) ? ST_TWALK : ST_TMUL;
        end
      end
      ST_TMUL: begin
        if (mcnt_r == 3'd6) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM:  state_nxt = (kz_r == '0) ? ST_DONE : ST_TPIX;
      ST_TPIX: begin
        if (covered) begin
          state_nxt = ST_TINTERP;
        end else if (walk_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_TINTERP: begin
        if (ip_rsp.done) begin
          state_nxt = ST_TREAD;
        end
      end
      ST_TREAD:  state_nxt = ST_TWRITE;
      ST_TWRITE: state_nxt = walk_end ? ST_DONE : ST_TPIX;
      ST_TWALK: begin
        if (hit_now) begin
          state_nxt = ST_DONE;
        end else if (walk_end) begin
          state_nxt = ST_TDRAIN;
        end
      end
      ST_TDRAIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_req       = '0;
    mem_req.raddr = pix_addr;
    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_cnt_r;
        mem_req.wdata = DEPTH_CLEAR;
      end
      ST_FILL: begin
        mem_req.we    = {2'b00, item_r.pixel_index} < area;
        mem_req.waddr = item_r.pixel_index;
        mem_req.wdata = sat_depth(item_r.az);
      end
      ST_TREAD, ST_TWALK: mem_req.re = 1'b1;
      ST_TWRITE: begin
        mem_req.we    = ip_rsp.depth < rd_data;
        mem_req.waddr = pix_addr;
        mem_req.wdata = ip_rsp.depth;
      end
      default: mem_req.re = 1'b0;
    endcase
  end

  always_comb begin
    ip_req       = '0;
    ip_req.start = (state_r == ST_TPIX) && covered;
    ip_req.w0    = w0_s;
    ip_req.w1    = ky_r;
    ip_req.w2    = kx_r;
    ip_req.sum   = kz_r;
    ip_req.z0    = item_r.az;
    ip_req.z1    = item_r.bz;
    ip_req.z2    = item_r.cz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_init_r  <= 1'b1;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      width_r     <= DIM_W'(MAX_WIDTH);
      height_r    <= DIM_W'(MAX_HEIGHT);
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= state_r == ST_TWALK;
      if (cfg_valid) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_r <= cfg_data;
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          height_r <= cfg_data;
        end
      end
      // load a new result, else drop the one just transferred
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            clr_cnt_r <= '0;
          end
        end
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
          if (clr_cnt_r == '1) begin
            clr_init_r <= 1'b0;
          end
        end
        default: clr_cnt_r <= clr_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        item_r <= in_data;
        cnt_r  <= '0;
        vis_r  <= 1'b0;
      end
      ST_BOX: begin
        box_x0_r <= bx0;
        box_x1_r <= bx1;
        box_y0_r <= by0;
        box_y1_r <= by1;
        dcax_r   <= (DIFF_W'(item_r.cx) - DIFF_W'(item_r.ax)) <<< 1;
        dcay_r   <= (DIFF_W'(item_r.cy) - DIFF_W'(item_r.ay)) <<< 1;
        dbax_r   <= (DIFF_W'(item_r.bx) - DIFF_W'(item_r.ax)) <<< 1;
        dbay_r   <= (DIFF_W'(item_r.by) - DIFF_W'(item_r.ay)) <<< 1;
      end
      ST_BASE: begin
        x_r        <= box_x0_r;
        y_r        <= box_y0_r;
        row_base_r <= base_prod[ADDR_W:0];
        mcnt_r     <= '0;
        // pixel center offset from vertex A, all doubled
        dapx_r <= $signed({item_r.ax[COORD_W-1], item_r.ax, 1'b0}) -
                  ($signed({12'b0, box_x0_r, 1'b1}) <<< COORD_FRAC_BITS);
        dapy_r <= $signed({item_r.ay[COORD_W-1], item_r.ay, 1'b0}) -
                  ($signed({12'b0, box_y0_r, 1'b1}) <<< COORD_FRAC_BITS);
      end
      ST_TMUL: begin
        prod_r <= mul_a * mul_b;
        mcnt_r <= mcnt_r + 3'd1;
        case (mcnt_r)
          3'd1:    kz_r <= prod_ext;
          3'd2:    kz_r <= kz_r - prod_ext;
          3'd3:    kx_r <= prod_ext;
          3'd4:    kx_r <= kx_r - prod_ext;
          3'd5:    ky_r <= prod_ext;
          3'd6:    ky_r <= ky_r - prod_ext;
          default: kz_r <= kz_r;
        endcase
      end
      ST_NORM: begin
        // flip signs so the weight sum is positive for either winding
        if (kz_r[K_W-1]) begin
          kz_r     <= kz_neg;
          kx_r     <= kx_neg;
          ky_r     <= ky_neg;
          kx_row_r <= kx_neg;
          ky_row_r <= ky_neg;
          ix_kx_r  <= -(sx(dbay_r) <<< (COORD_FRAC_BITS + 1));
          ix_ky_r  <= sx(dcay_r) <<< (COORD_FRAC_BITS + 1);
          iy_kx_r  <= sx(dbax_r) <<< (COORD_FRAC_BITS + 1);
          iy_ky_r  <= -(sx(dcax_r) <<< (COORD_FRAC_BITS + 1));
        end else begin
          kx_row_r <= kx_r;
          ky_row_r <= ky_r;
          ix_kx_r  <= sx(dbay_r) <<< (COORD_FRAC_BITS + 1);
          ix_ky_r  <= -(sx(dcay_r) <<< (COORD_FRAC_BITS + 1));
          iy_kx_r  <= -(sx(dbax_r) <<< (COORD_FRAC_BITS + 1));
          iy_ky_r  <= sx(dcax_r) <<< (COORD_FRAC_BITS + 1);
        end
      end
      ST_TWALK, ST_TDRAIN: begin
        if (hit_now) begin
          vis_r <= 1'b1;
        end
      end
      default: vis_r <= vis_r;
    endcase

    if (state_r == ST_TWRITE) begin
      cnt_r <= cnt_r + COUNT_W'(1);
    end

    // advance the walk: next pixel in the row, else the start of the next row
    if ((state_r == ST_TPIX && !covered) || state_r == ST_TWRITE ||
        (state_r == ST_TWALK && !hit_now)) begin
      if (!last_x) begin
        x_r  <= x_inc[DIM_W-1:0];
        kx_r <= kx_r + ix_kx_r;
        ky_r <= ky_r + ix_ky_r;
      end else if (!last_y) begin
        x_r        <= box_x0_r;
        y_r        <= y_inc[DIM_W-1:0];
        row_base_r <= row_base_r + (ADDR_W+1)'(w_act);
        kx_row_r   <= kx_row_r + iy_kx_r;
        ky_row_r   <= ky_row_r + iy_ky_r;
        kx_r       <= kx_row_r + iy_kx_r;
        ky_r       <= ky_row_r + iy_ky_r;
      end
    end

    if (state_r == ST_DONE && out_free) begin
      out_data_r.visible        <= vis_r;
      out_data_r.pixels_covered <= cnt_r;
    end
  end

  droe_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  droe_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ip_req),
    .rsp   (ip_rsp)
  );

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  a_test_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TWALK || state_r == ST_TDRAIN) |-> !mem_req.we)
    else $error("store written during a visibility test");

  a_interp_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    ip_rsp.done |-> state_r == ST_TINTERP)
    else $error("interpolation result arrived while not waiting for it");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r != ST_IDLE)
    else $error("transfer accepted but no operation started");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && state_r != ST_DONE) |=> !out_valid_r)
    else $error("result presented twice");

endmodule

[tb/tb_depth_raster_occlusion_engine.sv]
// ---------------------------------------------------------------------------
// tb_depth_raster_occlusion_engine: self-checking bench for the occlusion
// depth rasterizer
// Drives clear, fill, triangle and visibility-test operations under several
// frame sizes, predicts each result from a local depth store, and compares
// every result transfer with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_depth_raster_occlusion_engine;
  import droe_pkg::*;

  localparam int CYCLE_LIMIT = 12_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  droe_in_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  droe_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  depth_raster_occlusion_engine dut (.*);

  // local copy of the store and registers
  logic [DEPTH_W-1:0] depth_mem [STORE_DEPTH];
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  droe_out_t          pending_results [$];
  int                 err_count;
  int                 result_count;
  int                 cover_total;
  int                 visible_count;
  int                 cycle_count;
  bit                 no_gaps;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int active_dim(logic [DIM_W-1:0] r, int max_dim);
    if (r == 0) return 1;
    return (r > max_dim) ? max_dim : int'(r);
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [DEPTH_W-1:0] clip_depth(logic [127:0] v);
    return (v > 128'(DEPTH_CEILING)) ? DEPTH_CEILING : v[DEPTH_W-1:0];
  endfunction

  function automatic int raster_triangle(droe_in_t it, int w, int h);
    longint vx [3];
    longint vy [3];
    logic [DEPTH_W-1:0] vz [3];
    longint dcax, dcay, dbax, dbay, area2, x0, x1, y0, y1;
    longint px, py, dapx, dapy, kx, ky, area, w0, w1, w2;
    logic [127:0] acc;
    logic [DEPTH_W-1:0] d;
    int addr;
    int n;
    n = 0;
    vx[0] = it.ax; vy[0] = it.ay; vz[0] = it.az;
    vx[1] = it.bx; vy[1] = it.by; vz[1] = it.bz;
    vx[2] = it.cx; vy[2] = it.cy; vz[2] = it.cz;
    dcax = 2 * (vx[2] - vx[0]); dcay = 2 * (vy[2] - vy[0]);
    dbax = 2 * (vx[1] - vx[0]); dbay = 2 * (vy[1] - vy[0]);
    area2 = dcax * dbay - dbax * dcay;
    if (area2 == 0) return 0;
    x0 = vx[0]; x1 = vx[0]; y0 = vy[0]; y1 = vy[0];
    for (int i = 1; i < 3; i++) begin
      if (vx[i] < x0) x0 = vx[i];
      if (vx[i] > x1) x1 = vx[i];
      if (vy[i] < y0) y0 = vy[i];
      if (vy[i] > y1) y1 = vy[i];
    end
    x0 = clampl(x0 >>> COORD_FRAC_BITS, 0, w);
    x1 = clampl(-((-x1) >>> COORD_FRAC_BITS), 0, w);
    y0 = clampl(y0 >>> COORD_FRAC_BITS, 0, h);
    y1 = clampl(-((-y1) >>> COORD_FRAC_BITS), 0, h);
    for (longint y = y0; y < y1; y++) begin
      for (longint x = x0; x < x1; x++) begin
        px = (2 * x + 1) <<< COORD_FRAC_BITS;
        py = (2 * y + 1) <<< COORD_FRAC_BITS;
        dapx = 2 * vx[0] - px;
        dapy = 2 * vy[0] - py;
        kx = dbax * dapy - dapx * dbay;
        ky = dapx * dcay - dcax * dapy;
        area = area2;
        if (area < 0) begin
          area = -area; kx = -kx; ky = -ky;
        end
        w0 = area - kx - ky; w1 = ky; w2 = kx;
        if (w0 < 0 || w1 < 0 || w2 < 0) continue;
        acc = 128'(w0) * 128'(vz[0]) + 128'(w1) * 128'(vz[1]) + 128'(w2) * 128'(vz[2]);
        d = clip_depth(acc / 128'(area));
        addr = int'(y) * w + int'(x);
        if (d < depth_mem[addr]) depth_mem[addr] = d;
        n++;
      end
    end
    return n;
  endfunction

  function automatic logic rect_visible(droe_in_t it, int w, int h);
    longint x0, y0, x1, y1;
    x0 = clampl(it.ax, 0, w); y0 = clampl(it.ay, 0, h);
    x1 = clampl(it.bx, 0, w); y1 = clampl(it.by, 0, h);
    for (longint y = y0; y < y1; y++)
      for (longint x = x0; x < x1; x++)
        if (depth_mem[int'(y) * w + int'(x)] > it.az) return 1'b1;
    return 1'b0;
  endfunction

  function automatic droe_out_t predict_result(droe_in_t it);
    droe_out_t r;
    int w, h;
    w = active_dim(width_reg, MAX_WIDTH);
    h = active_dim(height_reg, MAX_HEIGHT);
    r = '0;
    case (it.op)
      OP_CLEAR: foreach (depth_mem[i]) depth_mem[i] = DEPTH_CLEAR;
      OP_FILL: begin
        if (int'(it.pixel_index) < w * h) depth_mem[it.pixel_index] = sat_depth(it.az);
      end
      OP_TRI: r.pixels_covered = COUNT_W'(raster_triangle(it, w, h));
      default: r.visible = rect_visible(it, w, h);
    endcase
    return r;
  endfunction

  task automatic send_op(droe_in_t it);
    while (!no_gaps && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      in_data <= droe_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom});
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_result(it));
  endtask

  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else if (idx == REG_FRAME_HEIGHT) height_reg = val;
  endtask

  task automatic set_frame(int w, int h);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, DIM_W'(w));
    write_reg(REG_FRAME_HEIGHT, DIM_W'(h));
  endtask

  function automatic droe_in_t make_op(logic [1:0] op);
    droe_in_t it;
    it = droe_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom});
    it.op = op;
    return it;
  endfunction

  function automatic droe_in_t make_tri(longint x, longint y, int reach);
    droe_in_t it;
    it = make_op(OP_TRI);
    it.ax = COORD_W'(x + $urandom_range(reach));
    it.ay = COORD_W'(y + $urandom_range(reach));
    it.bx = COORD_W'(x + $urandom_range(reach));
    it.by = COORD_W'(y + $urandom_range(reach));
    it.cx = COORD_W'(x + $urandom_range(reach));
    it.cy = COORD_W'(y + $urandom_range(reach));
    return it;
  endfunction

  function automatic droe_in_t make_rect(int w, int h);
    droe_in_t it;
    it = make_op(OP_TEST);
    it.ax = COORD_W'($urandom_range(w + 8) - 4);
    it.ay = COORD_W'($urandom_range(h + 8) - 4);
    it.bx = COORD_W'(int'(it.ax) + $urandom_range(6));
    it.by = COORD_W'(int'(it.ay) + $urandom_range(6));
    if ($urandom_range(3) == 0) it.az = $urandom_range(3) == 0 ? '1 : '0;
    return it;
  endfunction

  task automatic test_directed_ops();
    droe_in_t it;
    set_frame(16, 16);
    send_op(make_op(OP_CLEAR));
    it = make_op(OP_TEST);
    it.ax = 0; it.ay = 0; it.bx = 16; it.by = 16; it.az = DEPTH_CEILING;
    send_op(it);                                  // cleared store: all ones visible
    it.az = '1;
    send_op(it);
    it = make_op(OP_FILL); it.pixel_index = 0; it.az = '1;
    send_op(it);                                  // saturate to ceiling
    it.pixel_index = 255; it.az = '0;
    send_op(it);
    it.pixel_index = 256; it.az = '0;
    send_op(it);                                  // out of frame, ignored
    it.pixel_index = 16'hFFFF;
    send_op(it);
    it = make_op(OP_TEST);
    it.ax = 15; it.ay = 15; it.bx = 99; it.by = 99; it.az = 32'd5;
    send_op(it);
    it.ax = 5; it.bx = 5;
    send_op(it);                                  // empty rectangle
    it.ax = -20'sd524288; it.ay = -20'sd524288; it.bx = 20'sd524287; it.by = 20'sd524287;
    send_op(it);
    it = make_op(OP_TRI);
    it.ax = 16; it.ay = 16; it.bx = 100; it.by = 20; it.cx = 30; it.cy = 90;
    it.az = '0; it.bz = '1; it.cz = 32'h8000_0000;
    send_op(it);
    it.bx = 30; it.by = 90; it.cx = 100; it.cy = 20;
    send_op(it);                                  // other winding
    it.bx = 32; it.by = 32; it.cx = 64; it.cy = 64;
    send_op(it);                                  // collinear
    it.ax = 40; it.ay = 40; it.bx = 40; it.by = 40;
    send_op(it);
    it.ax = -20'sd524288; it.ay = -20'sd524288; it.bx = 20'sd524287; it.by = -20'sd524288;
    it.cx = -20'sd524288; it.cy = 20'sd524287; it.az = '1; it.bz = '1; it.cz = '1;
    send_op(it);                                  // huge triangle clipped to frame
    it = make_op(OP_TEST);
    it.ax = 0; it.ay = 0; it.bx = 16; it.by = 16; it.az = DEPTH_CEILING - 1;
    send_op(it);
  endtask

  task automatic test_frame_registers();
    droe_in_t it;
    set_frame(0, 0);                              // acts as 1x1
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, 9'h155);
    send_op(make_tri(-8, -8, 40));
    it = make_op(OP_FILL); it.pixel_index = 0; it.az = 32'h10;
    send_op(it);
    it.pixel_index = 1;
    send_op(it);
    send_op(make_rect(1, 1));
    set_frame(511, 256);                          // clamped to the maximum
    send_op(make_tri(255 * 16, 255 * 16, 40));
    send_op(make_tri(-16, 255 * 16, 40));
    it = make_op(OP_FILL); it.pixel_index = 16'hFFFF; it.az = 32'h1;
    send_op(it);
    it = make_op(OP_TEST);
    it.ax = 250; it.ay = 250; it.bx = 512; it.by = 512; it.az = 32'h1;
    send_op(it);
    set_frame(1, 256);
    send_op(make_tri(-16, 100 * 16, 64));
    send_op(make_rect(1, 256));
  endtask

  task automatic run_random(int n, int w, int h);
    droe_in_t it;
    int pick;
    for (int i = 0; i < n; i++) begin
      no_gaps = (i >= n / 4 && i < n / 2);
      if (i == 3 * n / 4) wait_drained();         // hold until everything is back
      pick = $urandom_range(99);
      if (pick < 1 && i % 200 == 0) it = make_op(OP_CLEAR);
      else if (pick < 25) begin
        it = make_op(OP_FILL);
        if ($urandom_range(3) != 0) it.pixel_index = 16'($urandom_range(w * h - 1));
      end else if (pick < 60) begin
        it = make_tri(longint'($urandom_range(w * 16 + 64)) - 32,
                      longint'($urandom_range(h * 16 + 64)) - 32,
                      $urandom_range(3) == 0 ? 24 : 80);
        if ($urandom_range(15) == 0) begin
          it.cx = it.ax + 2 * (it.bx - it.ax);
          it.cy = it.ay + 2 * (it.by - it.ay);    // degenerate
        end
      end else if (pick < 62) it = make_op(OP_TRI);
      else if (pick < 80) it = make_rect(w, h);
      else it = make_op(OP_TEST);
      send_op(it);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    set_frame(16, 16);
    run_random(500, 16, 16);
    set_frame(24, 9);
    run_random(400, 24, 9);
    set_frame(5, 40);
    run_random(400, 5, 40);
    set_frame(12, 1);
    run_random(300, 12, 1);
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    droe_out_t want;
    if (!rst_n) out_stall <= 1'b0;
    else begin
      out_stall <= !no_gaps && ($urandom_range(99) < 19);
      if (out_valid && !out_stall) begin
        result_count++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.visible !== want.visible) begin
            $display("%0t: visible expected %0d actual %0d", $time, want.visible,
                     out_data.visible);
            err_count++;
          end
          if (out_data.pixels_covered !== want.pixels_covered) begin
            $display("%0t: pixels_covered expected %0d actual %0d", $time,
                     want.pixels_covered, out_data.pixels_covered);
            err_count++;
          end
          cover_total += want.pixels_covered;
          visible_count += want.visible;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at %0t, %0d results outstanding", $time, pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    no_gaps = 1'b0;
    err_count = 0;
    result_count = 0;
    cover_total = 0;
    visible_count = 0;
    cycle_count = 0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    foreach (depth_mem[i]) depth_mem[i] = DEPTH_CLEAR;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_frame_registers();
    test_random_traffic();
    wait_drained();
    repeat (100) @(posedge clk);
    $display("%0d results checked over %0d cycles: %0d pixels covered, %0d visible tests",
             result_count, cycle_count, cover_total, visible_count);
    $display("frame sizes from 1x1 to 256x256, all four operations, both windings");
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/droe_pkg.sv
rtl/droe_store.sv
rtl/droe_interp.sv
rtl/depth_raster_occlusion_engine.sv
tb/tb_depth_raster_occlusion_engine.sv
